// ===== rtl/core/scancode_line_editor_assert.svh =====
// assertion macros used by the scle_edit module of the scancode line editor
`ifndef SCANCODE_LINE_EDITOR_ASSERT_SVH
`define SCANCODE_LINE_EDITOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SCLE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SCLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/scle_pkg.sv =====
// shared types, constants and keymap tables for the scancode line editor
`timescale 1ns / 1ps

package scle_pkg;

   // widths
   localparam int CAP_W  = 9;
   localparam int POS_W  = 8;
   localparam int CHAR_W = 7;
   localparam int CODE_W = 8;
   localparam int KIND_W = 2;

   // largest line buffer the hardware provides
   localparam int LINE_MAX = 256;
   localparam logic [CAP_W-1:0] CAP_CEIL  = CAP_W'((LINE_MAX < 256) ? LINE_MAX : 256);
   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   // scancodes of the shift keys
   localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;

   // keymap size and special characters
   localparam int MAP_SIZE = 58;
   localparam int MAP_IDX_W = $clog2(MAP_SIZE);
   localparam logic [CHAR_W-1:0] KEY_ENTER  = 7'd10;
   localparam logic [CHAR_W-1:0] KEY_BACK   = 7'd8;
   localparam logic [CHAR_W-1:0] PRINT_LOW  = 7'd32;
   localparam logic [CHAR_W-1:0] PRINT_HIGH = 7'd126;

   typedef enum logic [KIND_W-1:0] {
      EV_STORE = 2'd0,
      EV_ERASE = 2'd1,
      EV_END   = 2'd2
   } event_kind_type;

   // decoded scancode
   typedef struct packed {
      logic              shift_set;
      logic              shift_clr;
      logic              has_char;
      logic [CHAR_W-1:0] char_code;
   } dec_type;

   // item waiting in the input register, already decoded
   typedef struct packed {
      logic    valid;
      dec_type dec;
   } item_type;

   // US keymap, no shift
   localparam logic [CHAR_W-1:0] PLAIN_MAP [MAP_SIZE] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   // US keymap, shift held
   localparam logic [CHAR_W-1:0] SHIFT_MAP [MAP_SIZE] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

endpackage

// ===== rtl/core/scle_front.sv =====
// input register, shift flag and keymap lookup
`timescale 1ns / 1ps

module scle_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [scle_pkg::CODE_W-1:0]     req_scan_byte,
   input  logic                            take,
   output scle_pkg::item_type              item
);
   import scle_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              shift_ff, shift_in;
   logic              load;
   dec_type           dec;
   logic [CHAR_W-1:0] map_char;

   // input register frees up when its item moves on
   assign req_stall = in_valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      code_in     = code_ff;
      if (load) begin
         in_valid_in = 1'b1;
         code_in     = req_scan_byte;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   // keymap lookup on the held scancode
   always_comb begin
      map_char = shift_ff ? SHIFT_MAP[code_ff[MAP_IDX_W-1:0]]
                          : PLAIN_MAP[code_ff[MAP_IDX_W-1:0]];
      dec           = '0;
      dec.shift_set = (code_ff == SC_LSHIFT_MAKE) || (code_ff == SC_RSHIFT_MAKE);
      dec.shift_clr = (code_ff == SC_LSHIFT_BREAK) || (code_ff == SC_RSHIFT_BREAK);
      if (!dec.shift_set && code_ff < CODE_W'(MAP_SIZE)) begin
         dec.has_char  = (map_char != '0);
         dec.char_code = map_char;
      end
   end

   // shift flag follows items in order as they leave the input register
   always_comb begin
      shift_in = shift_ff;
      if (take && dec.shift_set) begin
         shift_in = 1'b1;
      end else if (take && dec.shift_clr) begin
         shift_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         shift_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         shift_ff    <= shift_in;
      end
      code_ff <= code_in;
   end

   assign item.valid = in_valid_ff;
   assign item.dec   = dec;

endmodule

// ===== rtl/core/scle_edit.sv =====
// line editor: capacity register, line position and result register
`timescale 1ns / 1ps
`include "scancode_line_editor_assert.svh"

module scle_edit (
   input  logic                            clock,
   input  logic                            reset,
   input  scle_pkg::item_type              item,
   output logic                            take,
   input  logic                            csr_write_en,
   input  logic [scle_pkg::CAP_W-1:0]      csr_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [scle_pkg::KIND_W-1:0]     rsp_event_kind,
   output logic [scle_pkg::CHAR_W-1:0]     rsp_char_code,
   output logic [scle_pkg::POS_W-1:0]      rsp_position
);
   import scle_pkg::*;

   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [POS_W-1:0]  line_pos_ff, line_pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   event_kind_type    kind_ff, kind_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CAP_W-1:0]  cap_clamped;
   logic [CAP_W-1:0]  store_limit;
   logic              emit;
   logic              printable;

   // item moves on when the result register is empty or being emptied
   assign take = item.valid && (!rsp_valid_ff || !rsp_stall);

   // capacity register
   assign cap_in = csr_write_en ? csr_write_data : cap_ff;

   // characters allowed in a line
   assign cap_clamped = (cap_ff > CAP_CEIL) ? CAP_CEIL : cap_ff;
   assign store_limit = (cap_clamped == '0) ? '0 : cap_clamped - 1'b1;
   assign printable   = (item.dec.char_code >= PRINT_LOW) &&
                        (item.dec.char_code <= PRINT_HIGH);

   // editing decision
   always_comb begin
      emit        = 1'b0;
      line_pos_in = line_pos_ff;
      kind_in     = kind_ff;
      char_in     = char_ff;
      pos_in      = pos_ff;
      if (take && item.dec.has_char) begin
         if (item.dec.char_code == KEY_ENTER) begin
            emit        = 1'b1;
            kind_in     = EV_END;
            char_in     = '0;
            pos_in      = line_pos_ff;
            line_pos_in = '0;
         end else if (item.dec.char_code == KEY_BACK) begin
            if (line_pos_ff != '0) begin
               emit        = 1'b1;
               kind_in     = EV_ERASE;
               char_in     = '0;
               pos_in      = line_pos_ff - 1'b1;
               line_pos_in = line_pos_ff - 1'b1;
            end
         end else if (printable && ({1'b0, line_pos_ff} < store_limit)) begin
            emit        = 1'b1;
            kind_in     = EV_STORE;
            char_in     = item.dec.char_code;
            pos_in      = line_pos_ff;
            line_pos_in = line_pos_ff + 1'b1;
         end
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = emit;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         line_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         line_pos_ff  <= line_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      char_ff <= char_in;
      pos_ff  <= pos_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_char_code  = char_ff;
   assign rsp_position   = pos_ff;

   // a held result always matches the line position it left behind
   `SCLE_ASSERT_SAME(a_end_clears_line, rsp_valid_ff && kind_ff == EV_END,
      line_pos_ff == '0 && char_ff == '0, "line end left a non-empty line")
   `SCLE_ASSERT_SAME(a_erase_length, rsp_valid_ff && kind_ff == EV_ERASE,
      line_pos_ff == pos_ff && char_ff == '0, "erase length disagrees with line")
   `SCLE_ASSERT_SAME(a_store_slot, rsp_valid_ff && kind_ff == EV_STORE,
      {1'b0, line_pos_ff} == {1'b0, pos_ff} + 9'd1, "stored slot disagrees with line")
   `SCLE_ASSERT_SAME(a_store_printable, rsp_valid_ff && kind_ff == EV_STORE,
      char_ff >= PRINT_LOW && char_ff <= PRINT_HIGH, "stored character not printable")
   `SCLE_ASSERT_NEXT(a_no_repeat, rsp_valid_ff && !rsp_stall && !take,
      !rsp_valid_ff, "taken result shown again")

endmodule

// ===== rtl/core/scancode_line_editor.sv =====
// set-1 scancode decoder feeding a line editor
// scancodes wait in the input register, their results in the result register
// throughput: one scancode per cycle while rsp is not stalled
// a stalled result holds the input register, which then stalls req
// reset (synchronous): shift released, empty line, capacity 256, no item held
`timescale 1ns / 1ps

module scancode_line_editor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [scle_pkg::CODE_W-1:0]     req_scan_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [scle_pkg::KIND_W-1:0]     rsp_event_kind,
   output logic [scle_pkg::CHAR_W-1:0]     rsp_char_code,
   output logic [scle_pkg::POS_W-1:0]      rsp_position,
   input  logic                            csr_write_en,
   input  logic [scle_pkg::CAP_W-1:0]      csr_write_data
);
   import scle_pkg::*;

   item_type item;
   logic     take;

   // input register and keymap
   scle_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_scan_byte (req_scan_byte),
      .take          (take),
      .item          (item)
   );

   // line editor and result register
   scle_edit u_edit (
      .clock          (clock),
      .reset          (reset),
      .item           (item),
      .take           (take),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_char_code  (rsp_char_code),
      .rsp_position   (rsp_position)
   );

endmodule
